[hw/rtl/cacc_pkg.sv]
// Shared types and constants of the closest-approach conflict check.
package cacc_pkg;

   // Unsigned Q15.16 fixed point: 31-bit registers and time result
   localparam int FRAC_BITS = 16;
   localparam int CFG_W     = 31;
   localparam int T_W       = 31;

   // Separation magnitude beyond which no radius can be met: 2^(CFG_W + FRAC_BITS)
   localparam int SEP_W = CFG_W + FRAC_BITS;

   // Input field layout
   localparam int IN_FIELDS = 12;
   localparam int POS1      = 0;
   localparam int VEL1      = 3;
   localparam int POS2      = 6;
   localparam int VEL2      = 9;

   // Result word: same_cell, conflict, second_evades, time_to_closest
   localparam int RSP_BITS = 3 + T_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_SAFETY_RADIUS  = 2'd0,
      REG_LOOKAHEAD_TIME = 2'd1,
      REG_CELL_SIZE      = 2'd2
   } reg_index_type;

endpackage

[hw/rtl/cacc_delay.sv]
// Enabled shift line that delays a word by a fixed number of stages.
module cacc_delay #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   generate
      if (N == 0) begin : g_pass
         assign dout = din;
      end else begin : g_line
         logic [W-1:0] line_ff [N];

         always_ff @(posedge clock) begin
            if (en) begin
               line_ff[0] <= din;
               for (int i = 1; i < N; i++) begin
                  line_ff[i] <= line_ff[i-1];
               end
            end
         end

         assign dout = line_ff[N-1];
      end
   endgenerate

endmodule

[hw/rtl/cacc_mul.sv]
// Two-stage signed multiplier built from four half-width partial products.
module cacc_mul #(
   parameter int A_W = 33,
   parameter int B_W = 33
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [A_W-1:0]      a,
   input  logic signed [B_W-1:0]      b,
   output logic signed [A_W+B_W-1:0]  p
);

   localparam int AL = (A_W + 1) / 2;
   localparam int AH = A_W - AL;
   localparam int BL = (B_W + 1) / 2;
   localparam int BH = B_W - BL;
   localparam int PW = A_W + B_W;

   logic signed [AL:0]   a_lo;
   logic signed [AH-1:0] a_hi;
   logic signed [BL:0]   b_lo;
   logic signed [BH-1:0] b_hi;

   logic signed [AL+BL+1:0] pp_ll_in, pp_ll_ff;
   logic signed [AL+BH:0]   pp_lh_in, pp_lh_ff;
   logic signed [AH+BL:0]   pp_hl_in, pp_hl_ff;
   logic signed [AH+BH-1:0] pp_hh_in, pp_hh_ff;
   logic signed [PW-1:0]    p_in, p_ff;

   assign a_lo = $signed({1'b0, a[AL-1:0]});
   assign a_hi = $signed(a[A_W-1:AL]);
   assign b_lo = $signed({1'b0, b[BL-1:0]});
   assign b_hi = $signed(b[B_W-1:BL]);

   always_comb begin
      pp_ll_in = a_lo * b_lo;
      pp_lh_in = a_lo * b_hi;
      pp_hl_in = a_hi * b_lo;
      pp_hh_in = a_hi * b_hi;
      p_in = PW'(pp_ll_ff)
           + (PW'(pp_lh_ff) <<< BL)
           + (PW'(pp_hl_ff) <<< AL)
           + (PW'(pp_hh_ff) <<< (AL + BL));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
         p_ff     <= p_in;
      end
   end

   assign p = p_ff;

endmodule

[hw/rtl/cacc_cell_idx.sv]
// Pipelined floor division of one coordinate by the cell size, one quotient bit a stage.
module cacc_cell_idx
   import cacc_pkg::*;
#(
   parameter int CW = 32
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [CW-1:0] coord,
   input  logic [CFG_W-1:0]     size,
   output logic signed [CW:0]   idx
);

   logic              neg_ff [CW+1];
   logic [CW-1:0]     mag_ff [CW];
   logic [CFG_W-1:0]  rem_ff [CW+1];
   logic [CW-1:0]     q_ff   [CW+1];
   logic [CW-1:0]     mag_in;
   logic signed [CW:0] idx_in, idx_ff;

   // Magnitude of the coordinate; the most negative value maps to 2^(CW-1)
   assign mag_in = coord[CW-1] ? CW'(-coord) : CW'(coord);

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= coord[CW-1];
         mag_ff[0] <= mag_in;
         rem_ff[0] <= '0;
         q_ff[0]   <= '0;
      end
   end

   generate
      for (genvar k = 1; k <= CW; k++) begin : g_step
         logic [CFG_W:0]   rs;
         logic             ge;
         logic [CFG_W-1:0] rem_in;
         logic [CW-1:0]    q_in;

         always_comb begin
            rs     = {rem_ff[k-1], mag_ff[k-1][CW-1]};
            ge     = rs >= {1'b0, size};
            rem_in = ge ? CFG_W'(rs - {1'b0, size}) : CFG_W'(rs);
            q_in   = {q_ff[k-1][CW-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               neg_ff[k] <= neg_ff[k-1];
               rem_ff[k] <= rem_in;
               q_ff[k]   <= q_in;
            end
         end

         if (k < CW) begin : g_shift
            always_ff @(posedge clock) begin
               if (en) begin
                  mag_ff[k] <= mag_ff[k-1] << 1;
               end
            end
         end
      end
   endgenerate

   // Round toward minus infinity for negative coordinates with a remainder
   assign idx_in = neg_ff[CW]
                 ? -((CW+1)'(q_ff[CW]) + (CW+1)'(rem_ff[CW] != '0))
                 : (CW+1)'(q_ff[CW]);

   always_ff @(posedge clock) begin
      if (en) begin
         idx_ff <= idx_in;
      end
   end

   assign idx = idx_ff;

endmodule

[hw/rtl/cacc_tdiv.sv]
// Pipelined restoring divider for the time to closest approach, one bit a stage.
module cacc_tdiv
   import cacc_pkg::*;
#(
   parameter int NUM_W = 66
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [NUM_W-1:0] vv,
   input  logic             go,
   output logic [T_W-1:0]   t
);

   // num * 2^FRAC_BITS is divided; its top part over 2^T_W seeds the remainder
   localparam int LOW_W = T_W - FRAC_BITS;

   logic [NUM_W-1:0] rem_ff [T_W];
   logic [NUM_W-1:0] vv_ff  [T_W];
   logic [LOW_W-1:0] lo_ff  [T_W];
   logic [T_W-1:0]   q_ff   [T_W+1];
   logic             go_ff  [T_W+1];
   logic             sat_ff [T_W+1];
   logic [NUM_W-1:0] r0;
   logic             sat_in;

   always_comb begin
      r0     = NUM_W'(num[NUM_W-1:LOW_W]);
      sat_in = r0 >= vv;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= r0;
         vv_ff[0]  <= vv;
         lo_ff[0]  <= num[LOW_W-1:0];
         q_ff[0]   <= '0;
         go_ff[0]  <= go;
         sat_ff[0] <= sat_in;
      end
   end

   generate
      for (genvar k = 1; k <= T_W; k++) begin : g_step
         logic             nb;
         logic [NUM_W:0]   rs;
         logic             ge;
         logic [NUM_W-1:0] rem_in;

         always_comb begin
            nb     = (k <= LOW_W) ? lo_ff[k-1][LOW_W-1] : 1'b0;
            rs     = {rem_ff[k-1], nb};
            ge     = rs >= {1'b0, vv_ff[k-1]};
            rem_in = ge ? NUM_W'(rs - {1'b0, vv_ff[k-1]}) : NUM_W'(rs);
         end

         always_ff @(posedge clock) begin
            if (en) begin
               q_ff[k]   <= {q_ff[k-1][T_W-2:0], ge};
               go_ff[k]  <= go_ff[k-1];
               sat_ff[k] <= sat_ff[k-1];
            end
         end

         if (k < T_W) begin : g_carry
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[k] <= rem_in;
                  vv_ff[k]  <= vv_ff[k-1];
                  lo_ff[k]  <= lo_ff[k-1] << 1;
               end
            end
         end
      end
   endgenerate

   // Zero when approaching is impossible, all ones on overflow
   assign t = !go_ff[T_W] ? '0 : (sat_ff[T_W] ? '1 : q_ff[T_W]);

endmodule

[hw/rtl/closest_approach_conflict_check.sv]
// Top level of the closest-approach conflict check for one pair of tracks.
//
// Usage: each transfer on the req_ stream carries one pair of tracks, twelve
// signed Q16.16 words of COORD_WIDTH bits (positions then velocities of the
// first track, then of the second). Each produces exactly one transfer on the
// rsp_ stream: same_cell, conflict, second_evades and the saturated time of
// closest approach in unsigned Q15.16 seconds. Safety radius, lookahead
// time and cell size are set over the csr_ APB port (byte addresses 0, 4, 8)
// while idle. Throughput is one pair per clock. The pipeline depth is set by
// the time divider, which runs one quotient bit per stage, and by the
// cell-index dividers, one bit per stage. When rsp_tready is low the
// pipeline still advances while its last stage or the output register is
// empty; once a result waits in the last stage behind an unaccepted one in
// the output register, everything holds and req_tready drops. Reset empties
// the pipeline and restores register defaults; nothing else needs clearing.
module closest_approach_conflict_check
   import cacc_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                          clock,
   input  logic                                          reset,
   // req_tdata: first_pos_x/y/z, first_vel_x/y/z, second_pos_x/y/z,
   //            second_vel_x/y/z, COORD_WIDTH bits each, zero padded to bytes
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [((IN_FIELDS*COORD_WIDTH+7)/8)*8-1:0]    req_tdata,
   // rsp_tdata: same_cell, conflict, second_evades, time_to_closest[30:0]
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [RSP_W-1:0]                              rsp_tdata,
   input  logic                                          csr_psel,
   input  logic                                          csr_penable,
   input  logic                                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]                         csr_paddr,
   input  logic [CSR_DATA_W-1:0]                         csr_pwdata,
   output logic [CSR_DATA_W-1:0]                         csr_prdata,
   output logic                                          csr_pready
);

   localparam int CW       = COORD_WIDTH;
   localparam int D        = CW + 1;
   localparam int VW       = 2 * D;
   localparam int DOT_W    = VW + 2;
   localparam int DT_W     = D + T_W + 1;
   localparam int SW       = DT_W + 1;
   localparam int SQ_W     = 2 * (SEP_W + 1);
   localparam int RR_W     = 2 * CFG_W;
   localparam int T_STAGE  = 5 + T_W + 1;
   localparam int CPA_LAT  = T_STAGE + 8;
   localparam int CELL_LAT = CW + 3;
   localparam int LAST     = (CPA_LAT > CELL_LAT) ? CPA_LAT : CELL_LAT;

   // ---------------- configuration ----------------
   logic [CFG_W-1:0] safety_radius_ff, lookahead_time_ff, cell_size_ff;
   logic [RR_W-1:0]  rr_in, rr_ff;
   logic             csr_wr;
   reg_index_type    csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         safety_radius_ff  <= CFG_W'(327680);
         lookahead_time_ff <= CFG_W'(1966080);
         cell_size_ff      <= CFG_W'(655360);
      end else if (csr_wr) begin
         case (csr_idx)
            REG_SAFETY_RADIUS:  safety_radius_ff  <= csr_pwdata[CFG_W-1:0];
            REG_LOOKAHEAD_TIME: lookahead_time_ff <= csr_pwdata[CFG_W-1:0];
            REG_CELL_SIZE:      cell_size_ff      <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_SAFETY_RADIUS:  csr_prdata = CSR_DATA_W'(safety_radius_ff);
         REG_LOOKAHEAD_TIME: csr_prdata = CSR_DATA_W'(lookahead_time_ff);
         REG_CELL_SIZE:      csr_prdata = CSR_DATA_W'(cell_size_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // Squared radius follows the register in the next cycle
   assign rr_in = RR_W'(safety_radius_ff) * RR_W'(safety_radius_ff);

   always_ff @(posedge clock) begin
      rr_ff <= rr_in;
   end

   // ---------------- flow control ----------------
   logic            en, out_load, rsp_valid_ff;
   logic [LAST:1]   v_in, v_ff;

   assign en         = !v_ff[LAST] || !rsp_valid_ff || rsp_tready;
   assign out_load   = en && v_ff[LAST];
   assign req_tready = en;
   assign v_in       = {v_ff[LAST-1:1], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // ---------------- field unpack ----------------
   logic signed [CW-1:0] fld [IN_FIELDS];

   generate
      for (genvar k = 0; k < IN_FIELDS; k++) begin : g_fld
         assign fld[k] = $signed(req_tdata[k*CW +: CW]);
      end
   endgenerate

   // ---------------- stage 1: differences ----------------
   logic signed [D-1:0] dp1_in [3], dp1_ff [3];
   logic signed [D-1:0] dv1_in [3], dv1_ff [3];
   logic                gt1_in, gt1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dp1_in[i] = D'(fld[POS1+i]) - D'(fld[POS2+i]);
         dv1_in[i] = D'(fld[VEL1+i]) - D'(fld[VEL2+i]);
      end
      gt1_in = fld[POS1+2] > fld[POS2+2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dp1_ff <= dp1_in;
         dv1_ff <= dv1_in;
         gt1_ff <= gt1_in;
      end
   end

   // ---------------- stages 2-3: dP.dV and dV.dV terms ----------------
   logic signed [VW-1:0] pdot3 [3];
   logic signed [VW-1:0] pvv3  [3];

   generate
      for (genvar i = 0; i < 3; i++) begin : g_dot
         cacc_mul #(.A_W(D), .B_W(D)) u_mdot (
            .clock (clock), .en (en), .a (dp1_ff[i]), .b (dv1_ff[i]), .p (pdot3[i])
         );
         cacc_mul #(.A_W(D), .B_W(D)) u_mvv (
            .clock (clock), .en (en), .a (dv1_ff[i]), .b (dv1_ff[i]), .p (pvv3[i])
         );
      end
   endgenerate

   // ---------------- stage 4: sums ----------------
   logic signed [DOT_W-1:0] dot4_in, dot4_ff, negdot;
   logic [VW-1:0]           vv4_in, vv4_ff;

   always_comb begin
      dot4_in = DOT_W'(pdot3[0]) + DOT_W'(pdot3[1]) + DOT_W'(pdot3[2]);
      vv4_in  = $unsigned(pvv3[0]) + $unsigned(pvv3[1]) + $unsigned(pvv3[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dot4_ff <= dot4_in;
         vv4_ff  <= vv4_in;
      end
   end

   // ---------------- stage 5: divider operands ----------------
   logic [VW-1:0] num5_ff, vv5_ff;
   logic          go5_ff;

   assign negdot = -dot4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         num5_ff <= negdot[VW-1:0];
         vv5_ff  <= vv4_ff;
         go5_ff  <= dot4_ff[DOT_W-1] && (vv4_ff != '0);
      end
   end

   // ---------------- time divider ----------------
   logic [T_W-1:0]    t_div;
   logic signed [T_W:0] t_sg;

   cacc_tdiv #(.NUM_W(VW)) u_tdiv (
      .clock (clock), .en (en), .num (num5_ff), .vv (vv5_ff), .go (go5_ff), .t (t_div)
   );

   assign t_sg = $signed({1'b0, t_div});

   // ---------------- relative state carried alongside ----------------
   logic [3*D-1:0] dv_pack, dv_dly, dp_pack, dp_dly;

   assign dv_pack = {dv1_ff[2], dv1_ff[1], dv1_ff[0]};
   assign dp_pack = {dp1_ff[2], dp1_ff[1], dp1_ff[0]};

   cacc_delay #(.W(3*D), .N(T_STAGE-1)) u_dv_dly (
      .clock (clock), .en (en), .din (dv_pack), .dout (dv_dly)
   );

   cacc_delay #(.W(3*D), .N(T_STAGE+1)) u_dp_dly (
      .clock (clock), .en (en), .din (dp_pack), .dout (dp_dly)
   );

   // ---------------- separation at time t ----------------
   logic signed [DT_W-1:0]  pdt [3];
   logic signed [SW-1:0]    s_in [3], s_ff [3];
   logic signed [SW-1:0]    s_abs [3];
   logic [SEP_W-1:0]        mag_in [3], mag_ff [3];
   logic [2:0]              far_in, far_ff, far_dly;
   logic signed [SQ_W-1:0]  psq [3];

   generate
      for (genvar i = 0; i < 3; i++) begin : g_sep
         logic signed [SEP_W:0] mag_sg;

         cacc_mul #(.A_W(D), .B_W(T_W+1)) u_mdt (
            .clock (clock), .en (en), .a ($signed(dv_dly[i*D +: D])), .b (t_sg),
            .p (pdt[i])
         );

         assign s_in[i]   = (SW'($signed(dp_dly[i*D +: D])) <<< FRAC_BITS) + SW'(pdt[i]);
         assign s_abs[i]  = s_ff[i][SW-1] ? -s_ff[i] : s_ff[i];
         assign mag_in[i] = s_abs[i][SEP_W-1:0];
         assign far_in[i] = |s_abs[i][SW-1:SEP_W];
         assign mag_sg    = $signed({1'b0, mag_ff[i]});

         cacc_mul #(.A_W(SEP_W+1), .B_W(SEP_W+1)) u_msq (
            .clock (clock), .en (en), .a (mag_sg), .b (mag_sg), .p (psq[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff   <= s_in;
         mag_ff <= mag_in;
         far_ff <= far_in;
      end
   end

   cacc_delay #(.W(3), .N(2)) u_far_dly (
      .clock (clock), .en (en), .din (far_ff), .dout (far_dly)
   );

   // ---------------- radius test ----------------
   logic [SQ_W-1:0] sum_in, sum_ff;
   logic            far_any_ff, near_in, near_ff;

   assign sum_in  = $unsigned(psq[0]) + $unsigned(psq[1]) + $unsigned(psq[2]);
   assign near_in = !far_any_ff
                 && (sum_ff <= SQ_W'({rr_ff, {(2*FRAC_BITS){1'b0}}}));

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff     <= sum_in;
         far_any_ff <= |far_dly;
         near_ff    <= near_in;
      end
   end

   // ---------------- grid cells ----------------
   logic signed [CW:0] idx [6];
   logic               same_in, same_ff;

   generate
      for (genvar k = 0; k < 6; k++) begin : g_cell
         cacc_cell_idx #(.CW(CW)) u_cell (
            .clock (clock),
            .en    (en),
            .coord ((k < 3) ? fld[POS1+k] : fld[POS2+k-3]),
            .size  (cell_size_ff),
            .idx   (idx[k])
         );
      end
   endgenerate

   // Zero cell size puts everything in one cell
   assign same_in = (cell_size_ff == '0)
                 || ((idx[0] == idx[3]) && (idx[1] == idx[4]) && (idx[2] == idx[5]));

   always_ff @(posedge clock) begin
      if (en) begin
         same_ff <= same_in;
      end
   end

   // ---------------- align at the last stage ----------------
   logic           same_e, near_e, gt_e;
   logic [T_W-1:0] t_e;

   cacc_delay #(.W(1), .N(LAST-CELL_LAT)) u_same_dly (
      .clock (clock), .en (en), .din (same_ff), .dout (same_e)
   );
   cacc_delay #(.W(1), .N(LAST-CPA_LAT)) u_near_dly (
      .clock (clock), .en (en), .din (near_ff), .dout (near_e)
   );
   cacc_delay #(.W(1), .N(LAST-1)) u_gt_dly (
      .clock (clock), .en (en), .din (gt1_ff), .dout (gt_e)
   );
   cacc_delay #(.W(T_W), .N(LAST-T_STAGE)) u_t_dly (
      .clock (clock), .en (en), .din (t_div), .dout (t_e)
   );

   // ---------------- output register ----------------
   logic           conflict_in;
   logic           same_out_ff, conflict_ff, evades_ff;
   logic [T_W-1:0] time_ff;

   assign conflict_in = same_e && near_e && (t_e <= lookahead_time_ff);

   always_ff @(posedge clock) begin
      if (out_load) begin
         same_out_ff <= same_e;
         conflict_ff <= conflict_in;
         evades_ff   <= conflict_in && gt_e;
         time_ff     <= t_e;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-RSP_BITS){1'b0}}, time_ff, evades_ff, conflict_ff, same_out_ff};

endmodule

[hw/rtl/cacc_checker.sv]
// Port-level checks of the closest-approach conflict check, bound to its top level.
module cacc_checker
   import cacc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // A conflict needs a shared cell
   a_conflict_same_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("conflict reported outside a shared cell");

   // Only a conflict names an evading track
   a_evade_needs_conflict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1])
      else $error("evasion reported without a conflict");

   // No result is valid right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result presented right after reset");

   // A stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

endmodule

bind closest_approach_conflict_check cacc_checker u_cacc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
